/* rtl/core/assert_macros.svh */
// Assertion macros shared by the character display interface RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check with asynchronous active-low reset disable.
`define CLNI_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("clni assertion failed");

// Same-cycle implication built on the check above.
`define CLNI_IMPLIES(lbl, clk, rst_n, ante, cons) \
	`CLNI_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))

`endif

/* rtl/core/clni_pkg.sv */
// Package with shared types, constants and helpers of the character display interface.
package clni_pkg;

	localparam int COLUMNS_DEF = 16;
	localparam int ROWS = 2;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int IDX_W = 5;
	localparam int OUT_DATA_W = 16;

	localparam logic [7:0] ROW1_BASE = 8'h40;
	localparam logic [7:0] SPACE_CHAR = 8'h20;
	localparam logic [7:0] TILDE_END = 8'h7F;
	localparam logic [7:0] SUBST_CHAR = 8'h3F;

	localparam logic [7:0] CMD_CLEAR = 8'h01;
	localparam logic [7:0] MASK_HOME = 8'hFE;
	localparam logic [7:0] CMD_HOME = 8'h02;
	localparam logic [7:0] MASK_ENTRY = 8'hFC;
	localparam logic [7:0] CMD_ENTRY = 8'h04;
	localparam logic [7:0] MASK_DISPLAY = 8'hF8;
	localparam logic [7:0] CMD_DISPLAY = 8'h08;
	localparam logic [7:0] MASK_FUNC = 8'hE0;
	localparam logic [7:0] CMD_FUNC = 8'h20;
	localparam logic [3:0] INIT_NIBBLE = 4'h2;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_DATA,
		OP_CLEAR,
		OP_HOME,
		OP_ENTRY,
		OP_DISPLAY,
		OP_ADDR
	} op_kind_t;

	typedef struct packed {
		op_kind_t kind;
		logic [7:0] value;
		logic backlight;
	} op_t;

	function automatic logic [7:0] printable(input logic [7:0] c);
		return (c >= SPACE_CHAR && c < TILDE_END) ? c : SUBST_CHAR;
	endfunction

endpackage

/* rtl/core/clni_front.sv */
// Front end: detects enable falling edges, pairs nibbles and classifies operations.
module clni_front
	import clni_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic [7:0] in_byte,
	output logic push,
	output op_t push_op
);

	logic [7:0] prev_byte_q;
	logic prev_en_q;
	logic [3:0] upper_q;
	logic upper_valid_q;
	logic init_q;

	logic accept;
	logic fall;
	logic rs;
	logic [3:0] nib;
	logic [7:0] full;
	op_kind_t kind;

	assign accept = in_valid && in_ready;
	assign fall = prev_en_q && !in_byte[2];
	assign rs = prev_byte_q[0];
	assign nib = prev_byte_q[7:4];
	assign full = {upper_q, nib};

	always_comb begin
		kind = OP_NONE;
		if (rs) begin
			kind = OP_DATA;
		end else if (full == CMD_CLEAR) begin
			kind = OP_CLEAR;
		end else if ((full & MASK_HOME) == CMD_HOME) begin
			kind = OP_HOME;
		end else if ((full & MASK_ENTRY) == CMD_ENTRY) begin
			kind = OP_ENTRY;
		end else if ((full & MASK_DISPLAY) == CMD_DISPLAY) begin
			kind = OP_DISPLAY;
		end else if ((full & MASK_FUNC) == CMD_FUNC) begin
			kind = OP_NONE;
		end else if (full[7]) begin
			kind = OP_ADDR;
		end
	end

	assign push = accept && fall && !init_q && upper_valid_q && (kind != OP_NONE);
	assign push_op = '{kind: kind, value: full, backlight: in_byte[3]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_byte_q <= '0;
			prev_en_q <= 1'b0;
			upper_q <= '0;
			upper_valid_q <= 1'b0;
			init_q <= 1'b1;
		end else if (accept) begin
			prev_byte_q <= in_byte;
			prev_en_q <= in_byte[2];
			if (fall) begin
				if (init_q) begin
					if (!rs && nib == INIT_NIBBLE) begin
						init_q <= 1'b0;
						upper_valid_q <= 1'b0;
					end
				end else if (!upper_valid_q) begin
					upper_q <= nib;
					upper_valid_q <= 1'b1;
				end else begin
					upper_valid_q <= 1'b0;
				end
			end
		end
	end

endmodule

/* rtl/core/clni_queue.sv */
// Short operation queue between the front end and the display back end.
module clni_queue
	import clni_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input op_t push_op,
	input logic pop,
	output logic full,
	output logic not_empty,
	output op_t head_op
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	op_t slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head_op = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/core/clni_back.sv */
// Back end: screen store, cursor, change tracking and the screen dump sequencer.
`include "assert_macros.svh"

module clni_back
	import clni_pkg::*;
#(
	parameter int COLUMNS = COLUMNS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic op_valid,
	input op_t op,
	output logic pop,
	output logic m_tvalid,
	input logic m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic m_tlast
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int IW = $clog2(CELLS);
	localparam logic [7:0] COL8 = 8'(COLUMNS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CHECK = 2'd1;
	localparam logic [1:0] ST_DUMP = 2'd2;

	logic [1:0] state_q;
	logic [7:0] screen_q [CELLS];
	logic [7:0] emitted_q [CELLS];
	logic [CELLS-1:0] mismatch_q;
	logic emitted_once_q;
	logic [7:0] cursor_q;
	logic incr_q;
	logic display_q;
	logic backlight_q;
	logic [IW-1:0] cnt_q;

	logic out_valid_q;
	logic [IDX_W-1:0] out_idx_q;
	logic [7:0] out_char_q;
	logic out_last_q;
	logic out_bl_q;
	logic out_disp_q;

	logic load;
	logic last_idx;
	logic in_row0;
	logic in_row1;
	logic [7:0] rel_addr;
	logic [IW-1:0] wr_idx;
	logic [7:0] data_pr;
	logic [7:0] cursor_next;
	logic dump_clean;

	assign pop = op_valid && (state_q == ST_IDLE);
	assign load = (state_q == ST_DUMP) && (!out_valid_q || m_tready);
	assign last_idx = (cnt_q == IW'(CELLS - 1));

	assign in_row0 = cursor_q < COL8;
	assign in_row1 = (cursor_q >= ROW1_BASE) && (cursor_q < ROW1_BASE + COL8);
	assign rel_addr = cursor_q - ROW1_BASE + COL8;
	assign wr_idx = in_row0 ? cursor_q[IW-1:0] : rel_addr[IW-1:0];
	assign data_pr = printable(op.value);
	assign dump_clean = (mismatch_q == '0) && emitted_once_q && (state_q == ST_IDLE);

	always_comb begin
		if (incr_q) begin
			cursor_next = cursor_q + 8'd1;
			if (cursor_next == COL8) begin
				cursor_next = ROW1_BASE;
			end else if (cursor_next == ROW1_BASE + COL8) begin
				cursor_next = 8'd0;
			end
		end else begin
			if (cursor_q == 8'd0) begin
				cursor_next = ROW1_BASE + COL8 - 8'd1;
			end else if (cursor_q == ROW1_BASE) begin
				cursor_next = COL8 - 8'd1;
			end else begin
				cursor_next = cursor_q - 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < CELLS; i++) begin
				screen_q[i] <= SPACE_CHAR;
				emitted_q[i] <= 8'h00;
			end
			mismatch_q <= '1;
			emitted_once_q <= 1'b0;
			cursor_q <= 8'd0;
			incr_q <= 1'b1;
			display_q <= 1'b0;
			backlight_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						backlight_q <= op.backlight;
						case (op.kind)
							OP_DATA: begin
								if (in_row0 || in_row1) begin
									screen_q[wr_idx] <= data_pr;
									mismatch_q[wr_idx] <= (data_pr != emitted_q[wr_idx]);
								end
								cursor_q <= cursor_next;
								state_q <= ST_CHECK;
							end
							OP_CLEAR: begin
								for (int i = 0; i < CELLS; i++) begin
									screen_q[i] <= SPACE_CHAR;
									mismatch_q[i] <= (emitted_q[i] != SPACE_CHAR);
								end
								cursor_q <= 8'd0;
								state_q <= ST_CHECK;
							end
							OP_HOME: cursor_q <= 8'd0;
							OP_ENTRY: incr_q <= op.value[1];
							OP_DISPLAY: display_q <= op.value[2];
							OP_ADDR: cursor_q <= {1'b0, op.value[6:0]};
							default: ;
						endcase
					end
				end
				ST_CHECK: begin
					cnt_q <= '0;
					state_q <= (!emitted_once_q || (|mismatch_q)) ? ST_DUMP : ST_IDLE;
				end
				ST_DUMP: begin
					if (load) begin
						emitted_q[cnt_q] <= screen_q[cnt_q];
						mismatch_q[cnt_q] <= 1'b0;
						cnt_q <= cnt_q + 1'b1;
						if (last_idx) begin
							emitted_once_q <= 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_idx_q <= IDX_W'(cnt_q);
			out_char_q <= screen_q[cnt_q];
			out_last_q <= last_idx;
			out_bl_q <= backlight_q;
			out_disp_q <= display_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {1'b0, out_disp_q, out_bl_q, out_char_q, out_idx_q};
	assign m_tlast = out_last_q;

	`CLNI_IMPLIES(a_pop_only_idle, clk, arst_n, pop, state_q == ST_IDLE)
	`CLNI_IMPLIES(a_load_has_room, clk, arst_n, load, !out_valid_q || m_tready)
	`CLNI_ASSERT(a_dump_end_clean, clk, arst_n, (load && last_idx) |=> dump_clean)

endmodule

/* rtl/core/char_lcd_nibble_interface.sv */
// Top level of the character display interface fed by expander pin bytes.
// Throughput: one input beat per cycle while the operation queue has room.
// A data write or clear passes through the back end check state, then 2*COLUMNS output
// beats (32 at the default) follow when the screen changed or none were sent yet; the
// dump loop sets this. The first output beat then leaves a registered output stage.
// Asynchronous active-low reset: screen holds spaces, init phase, no clearing pass.
module char_lcd_nibble_interface
	import clni_pkg::*;
#(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata, // expander_byte
	output logic m_tvalid,
	input logic m_tready,
	// char_index[4:0], shown_char[12:5], backlight_state[13], display_enabled[14], zero[15]
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic m_tlast // run_last
);

	logic push;
	op_t push_op;
	logic q_full;
	logic q_valid;
	op_t head_op;
	logic pop;

	assign s_tready = !q_full;

	clni_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_byte(s_tdata),
		.push(push),
		.push_op(push_op)
	);

	clni_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_op(push_op),
		.pop(pop),
		.full(q_full),
		.not_empty(q_valid),
		.head_op(head_op)
	);

	clni_back #(
		.COLUMNS(COLUMNS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.op_valid(q_valid),
		.op(head_op),
		.pop(pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

endmodule
